@@ rtl/ppt_pkg.sv @@
// Package: shared constants, codes and types for the promotable priority table.
`timescale 1ns / 1ps
package ppt_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_W     = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 31;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD      = 3'd0,
        F_PROMOTE  = 3'd1,
        F_GET_MAX  = 3'd2,
        F_POP_MAX  = 3'd3,
        F_IS_VALID = 3'd4,
        F_GET      = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BAD   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH,
        S_RESULT
    } t_state;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic               live;
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        t_entry          wdata;
        logic [ID_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic            clear;
        logic            step;
        logic [ID_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } t_best;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        logic               live;
    } t_result;

endpackage

@@ rtl/ppt_if.sv @@
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface ppt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ppt_pkg::FUNC_W-1:0]    func;
    logic [ppt_pkg::VALUE_W-1:0]   object_value;
    logic [ppt_pkg::ID_W-1:0]      item_id;

    modport source (output valid, func, object_value, item_id, input ready);
    modport sink   (input valid, func, object_value, item_id, output ready);
endinterface

interface ppt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppt_pkg::STATUS_W-1:0]  status;
    logic [ppt_pkg::ID_W-1:0]      result_id;
    logic [ppt_pkg::VALUE_W-1:0]   result_value;
    logic [ppt_pkg::PRIO_W-1:0]    result_priority;
    logic                          is_live;

    modport source (output valid, status, result_id, result_value, result_priority, is_live,
                    input ready);
    modport sink   (input valid, status, result_id, result_value, result_priority, is_live,
                    output ready);
endinterface

@@ rtl/ppt_store.sv @@
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ppt_store (
    input  logic              i_clk,
    input  ppt_pkg::t_mem_req i_req,
    output ppt_pkg::t_entry   o_rdata
);
    import ppt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ppt_unit.sv @@
// Shared compare unit: tracks the best live entry seen during a scan.
`timescale 1ns / 1ps
module ppt_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppt_pkg::t_scan_ctl i_ctl,
    input  ppt_pkg::t_entry    i_data,
    output ppt_pkg::t_best     o_best
);
    import ppt_pkg::*;

    logic               r_found;
    logic [ID_W-1:0]    r_best_id;
    logic [PRIO_W-1:0]  r_best_prio;
    logic [VALUE_W-1:0] r_best_value;
    logic               take;

    // >= so that a later (larger) id wins a tie
    assign take = i_ctl.step && i_data.live && (!r_found || i_data.prio >= r_best_prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_id    <= i_ctl.idx;
            r_best_prio  <= i_data.prio;
            r_best_value <= i_data.value;
        end
    end

    assign o_best = '{found: r_found, id: r_best_id, prio: r_best_prio, value: r_best_value};

endmodule

@@ rtl/ppt_seq.sv @@
// Sequencer: decodes a request, drives memory and compare unit, builds the result.
`timescale 1ns / 1ps
module ppt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppt_in_if.sink             i_in,
    input  ppt_pkg::t_entry    i_rdata,
    input  ppt_pkg::t_best     i_best,
    input  logic               i_res_ready,
    output ppt_pkg::t_mem_req  o_mem,
    output ppt_pkg::t_scan_ctl o_scan,
    output ppt_pkg::t_result   o_res
);
    import ppt_pkg::*;

    t_state             r_state, n_state;
    logic [FUNC_W-1:0]  r_func;
    logic [VALUE_W-1:0] r_value;
    logic [ID_W-1:0]    r_id;
    logic [CNT_W-1:0]   r_next_id, n_next_id;
    logic [CNT_W-1:0]   r_live_count, n_live_count;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_result            r_res, n_res;
    logic               id_hit;
    logic               accept;
    logic               scan_op;
    logic [CNT_W-1:0]   scan_idx;

    assign accept   = i_in.valid && i_in.ready;
    assign id_hit   = ({1'b0, r_id} < r_next_id) && i_rdata.live;
    assign scan_op  = (r_func == F_GET_MAX) || (r_func == F_POP_MAX);
    assign scan_idx = r_cnt - CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_EXEC;
            S_EXEC:   n_state = (scan_op && r_live_count != '0) ? S_SCAN : S_RESULT;
            S_SCAN:   if (r_cnt == r_next_id) n_state = S_FINISH;
            S_FINISH: n_state = S_RESULT;
            S_RESULT: if (i_res_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        logic [PRIO_W-1:0] new_prio;
        new_prio     = (i_rdata.prio == PRIO_MAX) ? PRIO_MAX : i_rdata.prio + PRIO_W'(1);
        o_mem        = '0;
        o_mem.raddr  = r_id;
        o_scan       = '0;
        n_res        = r_res;
        n_next_id    = r_next_id;
        n_live_count = r_live_count;
        n_cnt        = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_mem.raddr = i_in.item_id;
            end
            S_EXEC: begin
                n_res = '0;
                case (r_func)
                    F_ADD: begin
                        if (r_next_id == CAP_CNT) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_mem.we     = 1'b1;
                            o_mem.waddr  = r_next_id[ID_W-1:0];
                            o_mem.wdata  = '{live: 1'b1, prio: '0, value: r_value};
                            n_res.id     = r_next_id[ID_W-1:0];
                            n_next_id    = r_next_id + CNT_W'(1);
                            n_live_count = r_live_count + CNT_W'(1);
                        end
                    end
                    F_PROMOTE: begin
                        if (!id_hit) begin
                            n_res.status = ST_BAD;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_id;
                            o_mem.wdata = '{live: 1'b1, prio: new_prio, value: i_rdata.value};
                            n_res.id    = r_id;
                            n_res.prio  = new_prio;
                        end
                    end
                    F_GET_MAX, F_POP_MAX: begin
                        if (r_live_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            o_scan.clear = 1'b1;
                            o_mem.raddr  = '0;
                            n_cnt        = CNT_W'(1);
                        end
                    end
                    F_IS_VALID: begin
                        n_res.live = id_hit;
                    end
                    F_GET: begin
                        if (!id_hit) begin
                            n_res.status = ST_BAD;
                        end else begin
                            n_res.value = i_rdata.value;
                            n_res.live  = 1'b1;
                        end
                    end
                    default: begin
                        n_res.status = ST_BAD;
                    end
                endcase
            end
            S_SCAN: begin
                // read data belongs to the address issued in the cycle before
                o_scan.step = 1'b1;
                o_scan.idx  = scan_idx[ID_W-1:0];
                if (r_cnt != r_next_id) begin
                    o_mem.raddr = r_cnt[ID_W-1:0];
                    n_cnt       = r_cnt + CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (!i_best.found) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.id    = i_best.id;
                    n_res.value = i_best.value;
                    n_res.prio  = i_best.prio;
                    if (r_func == F_POP_MAX) begin
                        o_mem.we     = 1'b1;
                        o_mem.waddr  = i_best.id;
                        o_mem.wdata  = '{live: 1'b0, prio: i_best.prio, value: i_best.value};
                        n_live_count = r_live_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_id    <= '0;
            r_live_count <= '0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_next_id    <= n_next_id;
            r_live_count <= n_live_count;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_in.func;
            r_value <= i_in.object_value;
            r_id    <= i_in.item_id;
        end
        r_res <= n_res;
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        o_res       = r_res;
        o_res.valid = (r_state == S_RESULT);
    end

endmodule

@@ rtl/promotable_priority_table_top.sv @@
// Top level: promotable priority table with result register and checks.
`timescale 1ns / 1ps
// Table of up to 1024 entries (value plus 31-bit priority) with ids handed out
// in insertion order and never reused. One transaction is taken at a time: the
// request port is ready only while the sequencer is idle. add, promote,
// is_valid and get pass from acceptance to the result register through
// address issue, one read of the entry memory and the result stage.
// get_max and pop_max add a scan and a finish stage, since the single
// read port of the entry memory feeds the shared compare unit one entry per
// cycle across every id issued so far; an empty table skips the scan. The
// result register parts the two sides, so a new request may be accepted
// while a result still waits to be taken. Liveness is kept in the entry
// memory and bounded by the id counter, so no clearing pass follows reset. A
// pop_max retires the winner; ties in priority go to the larger id, and
// promote saturates at the largest priority.
module promotable_priority_table_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ppt_in_if.sink  i_in,
    ppt_out_if.source o_out
);
    import ppt_pkg::*;

    t_mem_req  mem_req;
    t_entry    rdata;
    t_scan_ctl scan_ctl;
    t_best     best;
    t_result   res;
    logic      res_ready;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_id;
    logic [VALUE_W-1:0] r_out_value;
    logic [PRIO_W-1:0]  r_out_prio;
    logic               r_out_live;

    ppt_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    ppt_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_data  (rdata),
        .o_best  (best)
    );

    ppt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_rdata     (rdata),
        .i_best      (best),
        .i_res_ready (res_ready),
        .o_mem       (mem_req),
        .o_scan      (scan_ctl),
        .o_res       (res)
    );

    // result register: free when empty or being drained this cycle
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_status <= res.status;
            r_out_id     <= res.id;
            r_out_value  <= res.value;
            r_out_prio   <= res.prio;
            r_out_live   <= res.live;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.result_id       = r_out_id;
    assign o_out.result_value    = r_out_value;
    assign o_out.result_priority = r_out_prio;
    assign o_out.is_live         = r_out_live;

    // a request handed over must lower ready until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request port still ready after acceptance");

    // sequencer never offers a result while it is taking a request
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && res.valid))
        else $error("result offered while idle");

    // a result moved into the register shows on the port next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && res_ready |=> o_out.valid)
        else $error("handed-over result not presented");

    // scan steps only come while a max search is under way
    a_scan_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_ctl.step |-> !i_in.ready && !res.valid)
        else $error("compare unit stepped outside a scan");

endmodule
